// ----- hw/rtl/glmd_pkg.sv -----
package glmd_pkg;

	// Grid limits and field widths.
	localparam int MAX_COLS    = 128;
	localparam int MAX_ROWS    = 1024;
	localparam int HEIGHT_BITS = 4;

	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_CNT_W = COL_W + 1;
	localparam int ROW_CNT_W = ROW_W + 1;

	// Configuration port.
	localparam int COLS_CFG_W  = 8;
	localparam int ROWS_CFG_W  = 11;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = CFG_INDEX_W'(1);

	localparam logic [COLS_CFG_W-1:0] GRID_COLS_RESET = COLS_CFG_W'(128);
	localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RESET = ROWS_CFG_W'(128);

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Verdict slots of one job, in output order.
	localparam int V_UPPER = 0;
	localparam int V_LEFT  = 1;
	localparam int V_FINAL = 2;
	localparam int N_VERDICTS = 3;

	typedef logic [HEIGHT_BITS-1:0] height_t;

	// One line buffer entry: the row above the incoming row and the row above that.
	typedef struct packed {
		height_t mid;
		height_t up;
	} line_word_t;

	// Everything the back end needs to emit the verdicts released by one word.
	typedef struct packed {
		logic [N_VERDICTS-1:0] vld;
		logic [N_VERDICTS-1:0] low;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		height_t               h_up;
		height_t               h_left;
		height_t               h_self;
	} glmd_job_t;

	typedef enum logic [1:0] {
		FETCH_RUN,
		FETCH_COL,
		FETCH_NEXT
	} glmd_fetch_t;

endpackage

// ----- hw/rtl/glmd_front.sv -----
module glmd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [glmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [glmd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [glmd_pkg::HEIGHT_BITS-1:0]   height,
	input  logic                               q_full,
	output logic                               push,
	output glmd_pkg::glmd_job_t                job
);

	logic [glmd_pkg::COLS_CFG_W-1:0] grid_cols_q;
	logic [glmd_pkg::ROWS_CFG_W-1:0] grid_rows_q;
	logic [glmd_pkg::COL_CNT_W-1:0]  cols_eff;
	logic [glmd_pkg::ROW_CNT_W-1:0]  rows_eff;

	logic [glmd_pkg::COL_W-1:0] col_q;
	logic [glmd_pkg::ROW_W-1:0] row_q;
	logic [glmd_pkg::COL_W-1:0] pc;
	logic [glmd_pkg::ROW_W-1:0] pr;
	logic [glmd_pkg::COL_W-1:0] nc;
	logic [glmd_pkg::ROW_W-1:0] nr;
	logic                       restart;
	logic [glmd_pkg::COL_CNT_W-1:0] col_inc;
	logic [glmd_pkg::COL_CNT_W-1:0] col_plus2;
	logic [glmd_pkg::COL_CNT_W-1:0] col_ahead;
	logic [glmd_pkg::ROW_CNT_W-1:0] row_inc;
	logic                       end_col;
	logic                       last_row;

	glmd_pkg::height_t left_q;
	glmd_pkg::height_t left_prev_q;
	glmd_pkg::height_t left2_q;

	glmd_pkg::glmd_fetch_t state_q;
	glmd_pkg::glmd_fetch_t state_nxt;

	glmd_pkg::line_word_t line_mem [glmd_pkg::MAX_COLS];
	glmd_pkg::line_word_t cur_word_q;
	glmd_pkg::line_word_t next_word_q;
	glmd_pkg::line_word_t new_word;
	logic [glmd_pkg::COL_W-1:0] rd_addr;
	logic                       mem_re;
	logic                       accept;
	logic                       small_c;
	logic                       one_c;

	// Configuration registers; a write always re-primes the line buffer window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= glmd_pkg::GRID_COLS_RESET;
			grid_rows_q <= glmd_pkg::GRID_ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				glmd_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data[glmd_pkg::COLS_CFG_W-1:0];
				glmd_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data[glmd_pkg::ROWS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_cols_q == '0) begin
			cols_eff = glmd_pkg::COL_CNT_W'(1);
		end else if (grid_cols_q > glmd_pkg::COLS_CFG_W'(glmd_pkg::MAX_COLS)) begin
			cols_eff = glmd_pkg::COL_CNT_W'(glmd_pkg::MAX_COLS);
		end else begin
			cols_eff = glmd_pkg::COL_CNT_W'(grid_cols_q);
		end
		if (grid_rows_q == '0) begin
			rows_eff = glmd_pkg::ROW_CNT_W'(1);
		end else if (grid_rows_q > glmd_pkg::ROWS_CFG_W'(glmd_pkg::MAX_ROWS)) begin
			rows_eff = glmd_pkg::ROW_CNT_W'(glmd_pkg::MAX_ROWS);
		end else begin
			rows_eff = glmd_pkg::ROW_CNT_W'(grid_rows_q);
		end
	end

	assign small_c = cols_eff <= glmd_pkg::COL_CNT_W'(2);
	assign one_c   = cols_eff == glmd_pkg::COL_CNT_W'(1);

	// Position of the incoming word; a position outside the grid restarts the frame.
	assign restart = (glmd_pkg::COL_CNT_W'(col_q) >= cols_eff) ||
	                 (glmd_pkg::ROW_CNT_W'(row_q) >= rows_eff);
	assign pc = restart ? '0 : col_q;
	assign pr = restart ? '0 : row_q;

	assign col_inc   = glmd_pkg::COL_CNT_W'(pc) + glmd_pkg::COL_CNT_W'(1);
	assign row_inc   = glmd_pkg::ROW_CNT_W'(pr) + glmd_pkg::ROW_CNT_W'(1);
	assign end_col   = col_inc >= cols_eff;
	assign last_row  = row_inc == rows_eff;
	assign col_plus2 = glmd_pkg::COL_CNT_W'(pc) + glmd_pkg::COL_CNT_W'(2);
	assign col_ahead = (col_plus2 >= cols_eff) ? (col_plus2 - cols_eff) : col_plus2;

	assign nc = end_col ? '0 : col_inc[glmd_pkg::COL_W-1:0];
	always_comb begin
		nr = pr;
		if (end_col) begin
			nr = (row_inc >= rows_eff) ? '0 : row_inc[glmd_pkg::ROW_W-1:0];
		end
	end

	// Prefetch sequencer: after a size change the window is reloaded from the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glmd_pkg::FETCH_RUN;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		mem_re    = 1'b0;
		rd_addr   = col_ahead[glmd_pkg::COL_W-1:0];
		case (state_q)
			glmd_pkg::FETCH_RUN: begin
				mem_re = accept;
			end
			glmd_pkg::FETCH_COL: begin
				state_nxt = glmd_pkg::FETCH_NEXT;
				mem_re    = 1'b1;
				rd_addr   = pc;
			end
			glmd_pkg::FETCH_NEXT: begin
				state_nxt = glmd_pkg::FETCH_RUN;
				mem_re    = 1'b1;
				rd_addr   = nc;
			end
			default: begin
				state_nxt = glmd_pkg::FETCH_RUN;
			end
		endcase
		if (cfg_we) begin
			state_nxt = glmd_pkg::FETCH_COL;
		end
	end

	assign in_stall = (state_q != glmd_pkg::FETCH_RUN) || q_full;
	assign accept   = in_valid && !in_stall;

	// The row two above is only refreshed once a row above exists.
	assign new_word.mid = height;
	assign new_word.up  = (pr != '0) ? cur_word_q.mid : cur_word_q.up;

	// Line buffer. With one or two columns the word ahead is the one being written.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[pc] <= new_word;
		end
		if (mem_re) begin
			next_word_q <= (accept && small_c) ? new_word : line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == glmd_pkg::FETCH_NEXT) begin
			cur_word_q <= next_word_q;
		end else if (accept) begin
			cur_word_q <= one_c ? new_word : next_word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			left_prev_q <= '0;
			left2_q     <= '0;
		end else if (accept) begin
			col_q       <= nc;
			row_q       <= nr;
			left_q      <= height;
			left_prev_q <= left_q;
			if (pr != '0) begin
				left2_q <= cur_word_q.mid;
			end
		end
	end

	// Classification of the verdicts this word releases.
	always_comb begin
		job        = '0;
		job.row    = pr;
		job.col    = pc;
		job.h_up   = cur_word_q.mid;
		job.h_left = left_q;
		job.h_self = height;

		job.vld[glmd_pkg::V_UPPER] = pr != '0;
		job.low[glmd_pkg::V_UPPER] =
			((pr == glmd_pkg::ROW_W'(1)) || (cur_word_q.up > cur_word_q.mid)) &&
			(height > cur_word_q.mid) &&
			((pc == '0) || (left2_q > cur_word_q.mid)) &&
			(end_col || (next_word_q.mid > cur_word_q.mid));

		job.vld[glmd_pkg::V_LEFT] = last_row && (pc != '0);
		job.low[glmd_pkg::V_LEFT] =
			((pr == '0) || (left2_q > left_q)) &&
			((pc == glmd_pkg::COL_W'(1)) || (left_prev_q > left_q)) &&
			(height > left_q);

		job.vld[glmd_pkg::V_FINAL] = last_row && end_col;
		job.low[glmd_pkg::V_FINAL] =
			((pr == '0) || (cur_word_q.mid > height)) &&
			((pc == '0) || (left_q > height));
	end

	assign push = accept && (job.vld != '0);

	a_no_push_while_fetching: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != glmd_pkg::FETCH_RUN) |-> !push)
		else $error("job pushed while the line window was being reloaded");

	a_cfg_reloads_window: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == glmd_pkg::FETCH_COL))
		else $error("size change did not start a window reload");

endmodule

// ----- hw/rtl/glmd_queue.sv -----
module glmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  glmd_pkg::glmd_job_t push_job,
	output logic                full,
	input  logic                pop,
	output glmd_pkg::glmd_job_t head,
	output logic                empty
);

	glmd_pkg::glmd_job_t              slot_q [glmd_pkg::QUEUE_DEPTH];
	logic [glmd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [glmd_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [glmd_pkg::QUEUE_CNT_W-1:0] cnt_q;

	assign full  = cnt_q == glmd_pkg::QUEUE_CNT_W'(glmd_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + glmd_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + glmd_pkg::QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + glmd_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - glmd_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule

// ----- hw/rtl/glmd_back.sv -----
module glmd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  glmd_pkg::glmd_job_t               head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [glmd_pkg::ROW_W-1:0]        cell_row,
	output logic [glmd_pkg::COL_W-1:0]        cell_col,
	output logic [glmd_pkg::HEIGHT_BITS-1:0]  cell_height,
	output logic                              is_low,
	output logic                              frame_last
);

	logic [glmd_pkg::N_VERDICTS-1:0] done_q;
	logic [glmd_pkg::N_VERDICTS-1:0] pending;
	logic [glmd_pkg::N_VERDICTS-1:0] pick;
	logic                            pick_final;
	logic                            load;

	logic                             out_valid_q;
	logic [glmd_pkg::ROW_W-1:0]       row_q;
	logic [glmd_pkg::COL_W-1:0]       col_q;
	glmd_pkg::height_t                height_q;
	logic                             low_q;
	logic                             last_q;

	// Verdicts of the head job go out in raster order: upper, left, final.
	assign pending    = head.vld & ~done_q;
	assign pick       = pending & (~pending + glmd_pkg::N_VERDICTS'(1));
	assign pick_final = (pending & ~pick) == '0;
	assign load       = !empty && (!out_valid_q || !out_stall);
	assign pop        = load && pick_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= pick_final ? '0 : (done_q | pick);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pick[glmd_pkg::V_UPPER]) begin
				row_q    <= head.row - glmd_pkg::ROW_W'(1);
				col_q    <= head.col;
				height_q <= head.h_up;
				low_q    <= head.low[glmd_pkg::V_UPPER];
				last_q   <= 1'b0;
			end else if (pick[glmd_pkg::V_LEFT]) begin
				row_q    <= head.row;
				col_q    <= head.col - glmd_pkg::COL_W'(1);
				height_q <= head.h_left;
				low_q    <= head.low[glmd_pkg::V_LEFT];
				last_q   <= 1'b0;
			end else begin
				row_q    <= head.row;
				col_q    <= head.col;
				height_q <= head.h_self;
				low_q    <= head.low[glmd_pkg::V_FINAL];
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign cell_row    = row_q;
	assign cell_col    = col_q;
	assign cell_height = height_q;
	assign is_low      = low_q;
	assign frame_last  = last_q;

	a_final_retires_job: assert property (@(posedge clk) disable iff (!arst_n)
		(load && pick[glmd_pkg::V_FINAL]) |-> pop)
		else $error("final verdict sent but its job stayed queued");

	a_load_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> $onehot(pick))
		else $error("verdict loaded from a job with nothing pending");

endmodule

// ----- hw/rtl/grid_local_minimum_detector.sv -----
// Four-neighbour local minimum detector. Height samples arrive one word per
// cycle, unless in_stall holds them off, in raster order, grid_cols words per
// row and grid_rows rows per frame; each result word says whether one cell is
// strictly lower than all of its existing up, down, left and right neighbours,
// with missing edge neighbours ignored. A cell is judged once the cell below it
// has arrived, so results trail the input by one row; in the last row each
// input word past column zero also releases the verdict for its left neighbour,
// and the final input word of the frame releases up to three verdicts, the last
// of them marked with frame_last. Input words are taken at one per cycle while
// in_stall is low; the output port moves one verdict per cycle while out_stall
// is low, so in the last row, where most words release two verdicts, the input
// is paced by the output port and the four-entry job queue between the front
// and back ends. With an empty queue and a free output port, a result passes
// from its input word into the job queue and then into the output register.
// The front end keeps the two previous rows in a single line buffer memory
// with at most one write and one registered read per cycle, reading two columns
// ahead of the incoming word. Writing either size register reloads that
// read-ahead window, which holds off input while the FETCH_COL and FETCH_NEXT
// states refetch it. Sizes of zero act as one, sizes above the maximum act as
// the maximum, and at the end of a frame the position wraps to the first cell
// of the next frame.
module grid_local_minimum_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [glmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [glmd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [glmd_pkg::HEIGHT_BITS-1:0]  height,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [glmd_pkg::ROW_W-1:0]        cell_row,
	output logic [glmd_pkg::COL_W-1:0]        cell_col,
	output logic [glmd_pkg::HEIGHT_BITS-1:0]  cell_height,
	output logic                              is_low,
	output logic                              frame_last
);

	// Jobs carry the classified verdicts of one input word from front to back.
	glmd_pkg::glmd_job_t push_job;
	glmd_pkg::glmd_job_t head_job;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;

	// Front end: position tracking, line buffer and neighbour comparisons.
	glmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.height    (height),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	// Short queue so that a stalled output does not immediately stall the input.
	glmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty)
	);

	// Back end: splits each job into its verdicts and holds the output register.
	glmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.cell_height (cell_height),
		.is_low      (is_low),
		.frame_last  (frame_last)
	);

endmodule

// ----- verif/grid_local_minimum_detector_checker.sv -----
module grid_local_minimum_detector_checker
	import glmd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  height_t                height,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [ROW_W-1:0]       cell_row,
	input  logic [COL_W-1:0]       cell_col,
	input  height_t                cell_height,
	input  logic                   is_low,
	input  logic                   frame_last,
	output int                     mismatches,
	output int                     verdicts_pending
);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		height_t          h;
		logic             low;
		logic             last;
	} verdict_t;

	// Shadow of the two buffered rows, the raster position and the size registers.
	height_t               older_row [MAX_COLS];
	height_t               recent_row [MAX_COLS];
	logic [COLS_CFG_W-1:0] cols_reg;
	logic [ROWS_CFG_W-1:0] rows_reg;
	int                    row_pos;
	int                    col_pos;
	height_t               left_h;
	height_t               diag_h;
	verdict_t              verdicts_due [$];

	initial begin
		mismatches = 0;
		verdicts_pending = 0;
	end

	function automatic int span_cols();
		if (cols_reg == '0)
			return 1;
		if (int'(cols_reg) > MAX_COLS)
			return MAX_COLS;
		return int'(cols_reg);
	endfunction

	function automatic int span_rows();
		if (rows_reg == '0)
			return 1;
		if (int'(rows_reg) > MAX_ROWS)
			return MAX_ROWS;
		return int'(rows_reg);
	endfunction

	task automatic queue_verdict(input int r, input int c, input height_t h,
			input logic low, input logic last);
		verdict_t v;
		v.row  = ROW_W'(r);
		v.col  = COL_W'(c);
		v.h    = h;
		v.low  = low;
		v.last = last;
		verdicts_due.push_back(v);
	endtask

	// Works out every verdict that one incoming height word releases.
	task automatic judge_word(input height_t h);
		int      ncols;
		int      nrows;
		int      r;
		int      c;
		height_t self;
		height_t nb;
		logic    low;
		ncols = span_cols();
		nrows = span_rows();
		if (col_pos >= ncols || row_pos >= nrows) begin
			col_pos = 0;
			row_pos = 0;
		end
		r = row_pos;
		c = col_pos;

		// The word completes the neighbourhood of the cell right above it.
		if (r >= 1) begin
			self = recent_row[c];
			nb   = (c + 1 < ncols) ? recent_row[c + 1] : '0;
			low  = (r == 1 || older_row[c] > self) && h > self &&
				(c == 0 || diag_h > self) && (c + 1 >= ncols || nb > self);
			queue_verdict(r - 1, c, self, low, 1'b0);
			older_row[c] = self;
			diag_h = self;
		end
		recent_row[c] = h;

		// In the bottom row the left neighbour, and at the end the word itself, are final.
		if (r == nrows - 1) begin
			if (c >= 1) begin
				self = left_h;
				nb   = (c >= 2) ? recent_row[c - 2] : '0;
				low  = (r == 0 || older_row[c - 1] > self) &&
					(c == 1 || nb > self) && h > self;
				queue_verdict(r, c - 1, self, low, 1'b0);
			end
			if (c == ncols - 1) begin
				low = (r == 0 || older_row[c] > h) && (c == 0 || left_h > h);
				queue_verdict(r, c, h, low, 1'b1);
			end
		end
		left_h = h;

		c++;
		if (c >= ncols) begin
			c = 0;
			r++;
			if (r >= nrows)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	task automatic check_verdict();
		verdict_t got;
		verdict_t want;
		got = {cell_row, cell_col, cell_height, is_low, frame_last};
		if (verdicts_due.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected verdict: row %0d col %0d height %0d low %0b last %0b",
					got.row, got.col, got.h, got.low, got.last);
			mismatches++;
		end else begin
			want = verdicts_due.pop_front();
			if (got !== want) begin
				if (mismatches < 10) begin
					$display("verdict mismatch: expected row %0d col %0d height %0d low %0b last %0b",
						want.row, want.col, want.h, want.low, want.last);
					$display("                  actual   row %0d col %0d height %0d low %0b last %0b",
						got.row, got.col, got.h, got.low, got.last);
				end
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg = GRID_COLS_RESET;
			rows_reg = GRID_ROWS_RESET;
			for (int i = 0; i < MAX_COLS; i++) begin
				older_row[i]  = '0;
				recent_row[i] = '0;
			end
			row_pos = 0;
			col_pos = 0;
			left_h  = '0;
			diag_h  = '0;
			verdicts_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRID_COLS)
					cols_reg = cfg_data[COLS_CFG_W-1:0];
				else if (cfg_index == REG_GRID_ROWS)
					rows_reg = cfg_data[ROWS_CFG_W-1:0];
			end
			if (in_valid && !in_stall)
				judge_word(height);
			if (out_valid && !out_stall)
				check_verdict();
		end
		verdicts_pending = verdicts_due.size();
	end

endmodule

// ----- verif/grid_local_minimum_detector_tb.sv -----
// Top of the local minimum detector bench. This module only makes stimulus and
// gives the verdict; the checker instantiated beside the block watches both
// channels, predicts every verdict word and compares it with what comes out.
module grid_local_minimum_detector_tb;
	import glmd_pkg::*;

	// Pacing of one phase: who, if anyone, inserts bubbles.
	typedef enum int {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	// Cycles with no word moving on either channel before the run is declared hung.
	// The longest deliberate receiver hold-off is well below this.
	localparam int QUIET_LIMIT  = 1000;
	// Cycles allowed after the last expected verdict before sizes change or the run ends.
	// A result follows its input through the job queue and the output register, so this is a generous margin.
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_STRETCH  = 60;
	localparam int RANDOM_ITEMS  = 110;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_GRID_COLS;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	height_t                height = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [ROW_W-1:0]       cell_row;
	logic [COL_W-1:0]       cell_col;
	height_t                cell_height;
	logic                   is_low;
	logic                   frame_last;

	int mismatches;
	int verdicts_pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;
	int band_lo = 0;
	int band_hi = 15;

	always #1 clk = ~clk;

	grid_local_minimum_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.height      (height),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.cell_height (cell_height),
		.is_low      (is_low),
		.frame_last  (frame_last)
	);

	grid_local_minimum_detector_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.height           (height),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.cell_row         (cell_row),
		.cell_col         (cell_col),
		.cell_height      (cell_height),
		.is_low           (is_low),
		.frame_last       (frame_last),
		.mismatches       (mismatches),
		.verdicts_pending (verdicts_pending)
	);

	// Receiver side. A requested hold-off keeps the output stalled for a fixed
	// number of cycles, counted here; otherwise the stall is a per-cycle coin toss
	// weighted by the current phase.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Hang detection: any accepted word on either side resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				idle_pct  = 58;
				stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				idle_pct  = 0;
				stall_pct = 58;
			end
			default: begin
				idle_pct  = 14;
				stall_pct = 14;
			end
		endcase
	endtask

	// Half the frames use the whole height range, the rest a narrow band so that
	// equal neighbours, which must defeat a strict minimum, show up often.
	task automatic pick_band();
		if ($urandom_range(1) == 1) begin
			band_lo = 0;
			band_hi = 15;
		end else begin
			band_lo = $urandom_range(13);
			band_hi = band_lo + $urandom_range(2);
		end
	endtask

	function automatic height_t random_height();
		return height_t'($urandom_range(band_hi, band_lo));
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken
	// with valid still high, so that a following word can go out without a bubble.
	task automatic send_word(input height_t h);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			height   <= height_t'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		height   <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering input and wait until every predicted verdict has come out.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (verdicts_pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_frame(input int cols, input int rows, input pace_t pace);
		drain();
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_GRID_ROWS, rows);
		set_pace(pace);
		pick_band();
		repeat (cols * rows) send_word(random_height());
	endtask

	initial begin
		height_t cross_grid [9];
		height_t tie_col [3];
		height_t dip_row [3];
		int      random_items;
		int      frame_idx;
		int      cols;
		int      rows;

		// A 3x3 frame of extremes: corners and centre at zero ringed by fifteens,
		// so the corner, edge and interior rules all fire. The last word releases
		// three verdicts.
		cross_grid = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0};
		// A single column of equal heights: no cell is strictly lower.
		tie_col = '{4'd4, 4'd4, 4'd4};
		// A single row with a dip in the middle.
		dip_row = '{4'd2, 4'd1, 4'd2};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		set_pace(PACE_FULL);
		write_reg(REG_GRID_COLS, 3);
		write_reg(REG_GRID_ROWS, 3);
		foreach (cross_grid[i])
			send_word(cross_grid[i]);

		// Zero sizes act as one: two one-cell frames, each cell a minimum on its own.
		drain();
		write_reg(REG_GRID_COLS, 0);
		write_reg(REG_GRID_ROWS, 0);
		send_word(4'd15);
		send_word(4'd0);

		drain();
		write_reg(REG_GRID_COLS, 1);
		write_reg(REG_GRID_ROWS, 3);
		foreach (tie_col[i])
			send_word(tie_col[i]);

		drain();
		write_reg(REG_GRID_COLS, 3);
		write_reg(REG_GRID_ROWS, 1);
		foreach (dip_row[i])
			send_word(dip_row[i]);

		// Full-width frame with an oversized row count, which acts as the maximum.
		// The first row runs against a busy receiver.
		drain();
		write_reg(REG_GRID_COLS, MAX_COLS);
		write_reg(REG_GRID_ROWS, 2047);
		set_pace(PACE_RECEIVER_STALL);
		band_lo = 0;
		band_hi = 15;
		repeat (MAX_COLS) send_word(random_height());

		// An oversized column count also acts as the maximum, so the frame carries on.
		// During the second row the receiver holds off for a long stretch while
		// words keep coming, which fills the job queue and backs up the input.
		drain();
		write_reg(REG_GRID_COLS, 255);
		@(posedge clk);
		hold_cycles = HOLD_STRETCH;
		@(negedge clk);
		set_pace(PACE_FULL);
		repeat (MAX_COLS) send_word(random_height());
		set_pace(PACE_SENDER_IDLE);
		repeat (5) send_word(random_height());

		// Shrinking the row count below the current row mid-frame restarts the
		// frame at the first cell on the next word.
		drain();
		write_reg(REG_GRID_ROWS, 0);

		// Random small frames, cycling through the pacing phases.
		random_items = 0;
		frame_idx = 0;
		while (random_items < RANDOM_ITEMS) begin
			cols = $urandom_range(8, 1);
			rows = $urandom_range(6, 1);
			run_frame(cols, rows, pace_t'(frame_idx % 4));
			random_items += cols * rows;
			frame_idx++;
		end

		drain();
		if (mismatches == 0 && verdicts_pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
